>>> hdl/mep_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel block.
// Used by the coordinate front end, the coordinate queue, the iteration core and the top level.
// Depends on nothing.
package mep_pkg;

   // Configuration as seen by the front end and the core.
   typedef struct packed {
      logic [63:0] center_re;
      logic [63:0] center_im;
      logic [62:0] pixel_step;
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic [15:0] iteration_cap;
   } cfg_type;

   // One mapped complex point c, signed fixed point.
   typedef struct packed {
      logic [63:0] cr;
      logic [63:0] ci;
   } coord_type;

   // Saturation limits of the signed 64-bit range.
   localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

>>> hdl/mep_front.sv
// Front end: accepts a pixel transaction and maps it to the complex point c.
// Uses mep_pkg for the configuration and coordinate types; feeds mep_queue.
module mep_front #(
   parameter int PIXEL_COORD_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mep_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [PIXEL_COORD_BITS-1:0] req_pixel_x,
   input  logic [PIXEL_COORD_BITS-1:0] req_pixel_y,
   output logic                        push_valid,
   input  logic                        push_ready,
   output mep_pkg::coord_type          push_data
);

   // Offset magnitude, offset product and doubled-sum widths.
   localparam int MW = (PIXEL_COORD_BITS + 1 > 13) ? PIXEL_COORD_BITS + 1 : 13;
   localparam int OW = MW + 63;
   localparam int CW = OW + 2;

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_SETUP = 3'd1;
   localparam logic [2:0] F_LO    = 3'd2;
   localparam logic [2:0] F_HI    = 3'd3;
   localparam logic [2:0] F_FIN   = 3'd4;
   localparam logic [2:0] F_PUSH  = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic                        axis_ff, axis_in;
   logic [PIXEL_COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [MW-1:0]               m_ff, m_in;
   logic                        neg_ff, neg_in;
   logic [OW-1:0]               off_ff, off_in;
   logic [63:0]                 cr_ff, cr_in, ci_ff, ci_in;

   logic [MW-1:0]    twice;
   logic [MW-1:0]    size;
   logic [MW+31:0]   p_lo;
   logic [MW+30:0]   p_hi;
   logic [63:0]      centre;
   logic [CW-1:0]    c2a;
   logic [CW-1:0]    offe;
   logic [CW-1:0]    c2;
   logic [CW-2:0]    half;
   logic [CW-65:0]   half_top;
   logic [63:0]      c_sat;

   // Offset setup, partial products of the offset, and the saturated halved sum.
   assign twice    = MW'({(axis_ff ? py_ff : px_ff), 1'b0});
   assign size     = MW'(axis_ff ? cfg.frame_height : cfg.frame_width);
   assign p_lo     = (MW+32)'(m_ff) * (MW+32)'(cfg.pixel_step[31:0]);
   assign p_hi     = (MW+31)'(m_ff) * (MW+31)'(cfg.pixel_step[62:32]);
   assign centre   = axis_ff ? cfg.center_im : cfg.center_re;
   assign c2a      = {{(CW-65){centre[63]}}, centre, 1'b0};
   assign offe     = CW'(off_ff);
   assign c2       = neg_ff ? (c2a - offe) : (c2a + offe);
   assign half     = c2[CW-1:1];
   assign half_top = half[CW-2:63];
   assign c_sat    = ((&half_top) || !(|half_top)) ? half[63:0] :
                     (half[CW-2] ? mep_pkg::SAT_MIN : mep_pkg::SAT_MAX);

   assign req_ready    = (state_ff == F_IDLE);
   assign push_valid   = (state_ff == F_PUSH);
   assign push_data.cr = cr_ff;
   assign push_data.ci = ci_ff;

   // Sequencer: real axis first, then imaginary, then hand the point to the queue.
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      off_in   = off_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               px_in    = req_pixel_x;
               py_in    = req_pixel_y;
               axis_in  = 1'b0;
               state_in = F_SETUP;
            end
         end
         F_SETUP: begin
            neg_in   = (twice < size);
            m_in     = (twice < size) ? (size - twice) : (twice - size);
            state_in = F_LO;
         end
         F_LO: begin
            off_in   = OW'(p_lo);
            state_in = F_HI;
         end
         F_HI: begin
            off_in   = off_ff + (OW'(p_hi) << 32);
            state_in = F_FIN;
         end
         F_FIN: begin
            if (axis_ff) begin
               ci_in    = c_sat;
               state_in = F_PUSH;
            end else begin
               cr_in    = c_sat;
               axis_in  = 1'b1;
               state_in = F_SETUP;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      off_ff  <= off_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
   end

endmodule

>>> hdl/mep_queue.sv
// Two-entry queue of mapped points between the front end and the iteration core.
// Uses mep_pkg::coord_type for its entries.
module mep_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mep_pkg::coord_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mep_pkg::coord_type pop_data
);

   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);

   mep_pkg::coord_type entry_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? AW'((wr_ptr_ff + 1'b1) % DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_pop ? AW'((rd_ptr_ff + 1'b1) % DEPTH) : rd_ptr_ff;
      cnt_in    = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/mep_core.sv
// Iteration core: runs z = z*z + c on one shared 32x32 multiplier, then divides and colors.
// Uses mep_pkg for configuration, coordinate types and saturation limits; fed by mep_queue.
module mep_core #(
   parameter int FRAC_BITS = 56
) (
   input  logic               clock,
   input  logic               reset,
   input  mep_pkg::cfg_type   cfg,
   input  logic               q_valid,
   output logic               q_ready,
   input  mep_pkg::coord_type q_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [15:0]        rsp_iteration_count,
   output logic               rsp_in_set,
   output logic [31:0]        rsp_pixel_argb
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_TEST  = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_FIN   = 4'd4;
   localparam logic [3:0] S_UPD   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_CINIT = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   // Products run through the shared multiplier.
   localparam logic [3:0] OP_XY  = 4'd0;
   localparam logic [3:0] OP_XX  = 4'd1;
   localparam logic [3:0] OP_YY  = 4'd2;
   localparam logic [3:0] OP_TT  = 4'd3;
   localparam logic [3:0] OP_T3  = 4'd4;
   localparam logic [3:0] OP_UU  = 4'd5;
   localparam logic [3:0] OP_U3  = 4'd6;
   localparam logic [3:0] OP_KU  = 4'd7;
   localparam logic [3:0] OP_KT2 = 4'd8;
   localparam logic [3:0] OP_KT  = 4'd9;
   localparam logic [3:0] OP_R   = 4'd10;
   localparam logic [3:0] OP_G   = 4'd11;
   localparam logic [3:0] OP_B   = 4'd12;

   // Gradient coefficients are 255 times 9, 15 and 17 (the last one halved at the end, for 8.5).
   localparam logic [63:0] COEF_R = 64'd2295;
   localparam logic [63:0] COEF_G = 64'd3825;
   localparam logic [63:0] COEF_B = 64'd4335;
   localparam logic [64:0] FOUR   = 65'd4 << FRAC_BITS;
   localparam logic [31:0] BLACK  = 32'hFF00_0000;
   localparam logic [7:0]  ALPHA  = 8'hFF;

   logic [3:0]   state_ff, state_in, op_ff, op_in;
   logic [1:0]   k_ff, k_in;
   logic [3:0]   div_cnt_ff, div_cnt_in;
   logic [63:0]  cr_ff, cr_in, ci_ff, ci_in;
   logic [63:0]  zr_ff, zr_in, zi_ff, zi_in, zr2_ff, zr2_in, zi2_ff, zi2_in;
   logic [63:0]  diff_ff, diff_in, prod_ff, prod_in;
   logic [15:0]  count_ff, count_in;
   logic         in_set_ff, in_set_in;
   logic [63:0]  mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [15:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [15:0]  t_ff, t_in;
   logic [16:0]  u_ff, u_in;
   logic [31:0]  t2_ff, t2_in;
   logic [47:0]  t3_ff, t3_in;
   logic [32:0]  u2_ff, u2_in;
   logic [48:0]  u3_ff, u3_in;
   logic [28:0]  ku_ff, ku_in, kt_ff, kt_in;
   logic [43:0]  kt2_ff, kt2_in;
   logic [7:0]   r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic         out_valid_ff, out_valid_in;
   logic [15:0]  out_count_ff, out_count_in;
   logic         out_in_set_ff, out_in_set_in;
   logic [31:0]  out_argb_ff, out_argb_in;

   logic [63:0]  opa, opb, mag_a, mag_b;
   logic         op_signed;
   logic [31:0]  a_sel, b_sel;
   logic [63:0]  pp;
   logic [127:0] pp_wide;
   logic [127:0] p_signed;
   logic [127:0] fin_sh;
   logic [64:0]  fin_top;
   logic [63:0]  fin_sat;
   logic [64:0]  esc_sum;
   logic [16:0]  rem_sh;
   logic [16:0]  cap_ext;
   logic [7:0]   clamp_rg, clamp_b;

   // Saturating signed add and subtract.
   function automatic logic [63:0] s_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if ((a[63] == b[63]) && (s[63] != a[63])) begin
         s = a[63] ? mep_pkg::SAT_MIN : mep_pkg::SAT_MAX;
      end
      return s;
   endfunction

   function automatic logic [63:0] s_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a - b;
      if ((a[63] != b[63]) && (s[63] != a[63])) begin
         s = a[63] ? mep_pkg::SAT_MIN : mep_pkg::SAT_MAX;
      end
      return s;
   endfunction

   // Operand selection for the current product.
   always_comb begin
      case (op_ff)
         OP_XY:   begin opa = zr_ff;        opb = zi_ff;         end
         OP_XX:   begin opa = zr_ff;        opb = zr_ff;         end
         OP_YY:   begin opa = zi_ff;        opb = zi_ff;         end
         OP_TT:   begin opa = 64'(t_ff);    opb = 64'(t_ff);     end
         OP_T3:   begin opa = 64'(t2_ff);   opb = 64'(t_ff);     end
         OP_UU:   begin opa = 64'(u_ff);    opb = 64'(u_ff);     end
         OP_U3:   begin opa = 64'(u2_ff);   opb = 64'(u_ff);     end
         OP_KU:   begin opa = 64'(u_ff);    opb = COEF_R;        end
         OP_KT2:  begin opa = 64'(t2_ff);   opb = COEF_G;        end
         OP_KT:   begin opa = 64'(t_ff);    opb = COEF_B;        end
         OP_R:    begin opa = 64'(t3_ff);   opb = 64'(ku_ff);    end
         OP_G:    begin opa = 64'(u2_ff);   opb = 64'(kt2_ff);   end
         OP_B:    begin opa = 64'(kt_ff);   opb = 64'(u3_ff);    end
         default: begin opa = '0;           opb = '0;            end
      endcase
   end

   assign op_signed = (op_ff == OP_XY) || (op_ff == OP_XX) || (op_ff == OP_YY);
   assign mag_a     = (op_signed && opa[63]) ? (~opa + 64'd1) : opa;
   assign mag_b     = (op_signed && opb[63]) ? (~opb + 64'd1) : opb;

   // One 32x32 partial product per cycle, placed at its word offset.
   assign a_sel = k_ff[0] ? mag_a_ff[63:32] : mag_a_ff[31:0];
   assign b_sel = k_ff[1] ? mag_b_ff[63:32] : mag_b_ff[31:0];
   assign pp    = {32'd0, a_sel} * {32'd0, b_sel};

   always_comb begin
      case (k_ff)
         2'd0:    pp_wide = {64'd0, pp};
         2'd3:    pp_wide = {pp, 64'd0};
         default: pp_wide = {32'd0, pp, 32'd0};
      endcase
   end

   // Sign, floor shift and saturation of a finished iteration product.
   assign p_signed = neg_ff ? (~acc_ff + 128'd1) : acc_ff;
   assign fin_sh   = (op_ff == OP_XY) ? 128'($signed(p_signed) >>> (FRAC_BITS - 1)) :
                                        128'($signed(p_signed) >>> FRAC_BITS);
   assign fin_top  = fin_sh[127:63];
   assign fin_sat  = ((&fin_top) || !(|fin_top)) ? fin_sh[63:0] :
                     (fin_sh[127] ? mep_pkg::SAT_MIN : mep_pkg::SAT_MAX);

   // Escape test, divider step and channel clamps.
   assign esc_sum  = {1'b0, zr2_ff} + {1'b0, zi2_ff};
   assign rem_sh   = {rem_ff, 1'b0};
   assign cap_ext  = {1'b0, cfg.iteration_cap};
   assign clamp_rg = (|acc_ff[127:72]) ? 8'hFF : acc_ff[71:64];
   assign clamp_b  = (|acc_ff[127:73]) ? 8'hFF : acc_ff[72:65];

   assign rsp_valid           = out_valid_ff;
   assign rsp_iteration_count = out_count_ff;
   assign rsp_in_set          = out_in_set_ff;
   assign rsp_pixel_argb      = out_argb_ff;

   // Sequencer for the iteration, the quotient and the color products.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      k_in          = k_ff;
      div_cnt_in    = div_cnt_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      zr2_in        = zr2_ff;
      zi2_in        = zi2_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      count_in      = count_ff;
      in_set_in     = in_set_ff;
      mag_a_in      = mag_a_ff;
      mag_b_in      = mag_b_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      t_in          = t_ff;
      u_in          = u_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      u2_in         = u2_ff;
      u3_in         = u3_ff;
      ku_in         = ku_ff;
      kt_in         = kt_ff;
      kt2_in        = kt2_ff;
      r_in          = r_ff;
      g_in          = g_ff;
      b_in          = b_ff;
      out_valid_in  = out_valid_ff;
      out_count_in  = out_count_ff;
      out_in_set_in = out_in_set_ff;
      out_argb_in   = out_argb_ff;
      q_ready       = 1'b0;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_ready  = 1'b1;
               cr_in    = q_data.cr;
               ci_in    = q_data.ci;
               zr_in    = '0;
               zi_in    = '0;
               zr2_in   = '0;
               zi2_in   = '0;
               count_in = '0;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if ((esc_sum <= FOUR) && (count_ff < cfg.iteration_cap)) begin
               diff_in  = s_sub(zr2_ff, zi2_ff);
               op_in    = OP_XY;
               state_in = S_LOAD;
            end else begin
               in_set_in  = (count_ff == cfg.iteration_cap);
               rem_in     = count_ff;
               quo_in     = '0;
               div_cnt_in = '0;
               state_in   = (count_ff == cfg.iteration_cap) ? S_DONE : S_DIV;
            end
         end
         S_LOAD: begin
            mag_a_in = mag_a;
            mag_b_in = mag_b;
            neg_in   = op_signed && (opa[63] ^ opb[63]);
            acc_in   = '0;
            k_in     = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in = acc_ff + pp_wide;
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_LOAD;
            case (op_ff)
               OP_XY: begin
                  prod_in  = fin_sat;
                  state_in = S_UPD;
               end
               OP_XX: begin
                  zr2_in = fin_sat;
                  op_in  = OP_YY;
               end
               OP_YY: begin
                  zi2_in   = fin_sat;
                  count_in = count_ff + 16'd1;
                  state_in = S_TEST;
               end
               OP_TT:  begin t2_in  = acc_ff[31:0]; op_in = OP_T3;  end
               OP_T3:  begin t3_in  = acc_ff[47:0]; op_in = OP_UU;  end
               OP_UU:  begin u2_in  = acc_ff[32:0]; op_in = OP_U3;  end
               OP_U3:  begin u3_in  = acc_ff[48:0]; op_in = OP_KU;  end
               OP_KU:  begin ku_in  = acc_ff[28:0]; op_in = OP_KT2; end
               OP_KT2: begin kt2_in = acc_ff[43:0]; op_in = OP_KT;  end
               OP_KT:  begin kt_in  = acc_ff[28:0]; op_in = OP_R;   end
               OP_R:   begin r_in   = clamp_rg;     op_in = OP_G;   end
               OP_G:   begin g_in   = clamp_rg;     op_in = OP_B;   end
               OP_B: begin
                  b_in     = clamp_b;
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_UPD: begin
            zi_in    = s_add(prod_ff, ci_ff);
            zr_in    = s_add(diff_ff, cr_ff);
            op_in    = OP_XX;
            state_in = S_LOAD;
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (rem_sh >= cap_ext) begin
               rem_in = 16'(rem_sh - cap_ext);
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh[15:0];
               quo_in = {quo_ff[14:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'd15) begin
               state_in = S_CINIT;
            end
         end
         S_CINIT: begin
            t_in     = quo_ff;
            u_in     = 17'h1_0000 - 17'(quo_ff);
            op_in    = OP_TT;
            state_in = S_LOAD;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in  = 1'b1;
               out_count_in  = count_ff;
               out_in_set_in = in_set_ff;
               out_argb_in   = in_set_ff ? BLACK : {ALPHA, r_ff, g_ff, b_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      k_ff          <= k_in;
      div_cnt_ff    <= div_cnt_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      zr2_ff        <= zr2_in;
      zi2_ff        <= zi2_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      count_ff      <= count_in;
      in_set_ff     <= in_set_in;
      mag_a_ff      <= mag_a_in;
      mag_b_ff      <= mag_b_in;
      neg_ff        <= neg_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      t_ff          <= t_in;
      u_ff          <= u_in;
      t2_ff         <= t2_in;
      t3_ff         <= t3_in;
      u2_ff         <= u2_in;
      u3_ff         <= u3_in;
      ku_ff         <= ku_in;
      kt_ff         <= kt_in;
      kt2_ff        <= kt2_in;
      r_ff          <= r_in;
      g_ff          <= g_in;
      b_ff          <= b_in;
      out_count_ff  <= out_count_in;
      out_in_set_ff <= out_in_set_in;
      out_argb_ff   <= out_argb_in;
   end

endmodule

>>> hdl/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel evaluator: register file, front end, queue and iteration core.
// Depends on mep_pkg, mep_front, mep_queue and mep_core.
//
// A pixel transaction is mapped to c by the front end and waits in a two-entry
// queue, so mapping overlaps the previous pixel's iteration. In each escape iteration the
// core runs three 64x64 products, each of which makes four passes through one shared
// 32x32 multiplier plus a load and a finish step. A pixel that reaches the cap then goes
// straight to the output; an escaping pixel first needs a 16-bit quotient and ten color
// products on the same multiplier. A finished result waits in an output register while
// the next pixel already runs.
module mandelbrot_escape_pixel #(
   parameter int FRAC_BITS        = 56,
   parameter int PIXEL_COORD_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [PIXEL_COORD_BITS-1:0] req_pixel_x,
   input  logic [PIXEL_COORD_BITS-1:0] req_pixel_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [15:0]                 rsp_iteration_count,
   output logic                        rsp_in_set,
   output logic [31:0]                 rsp_pixel_argb,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [5:0]                  csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam logic [2:0] REG_CENTER_RE     = 3'd0;
   localparam logic [2:0] REG_CENTER_IM     = 3'd1;
   localparam logic [2:0] REG_PIXEL_STEP    = 3'd2;
   localparam logic [2:0] REG_FRAME_WIDTH   = 3'd3;
   localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd4;
   localparam logic [2:0] REG_ITERATION_CAP = 3'd5;

   // Reset view: centre at -0.5, four units across an 800 by 600 frame, cap of 256.
   localparam logic [63:0] CENTER_RE_RESET = ~((64'd1 << (FRAC_BITS - 1)) - 64'd1);
   localparam logic [63:0] STEP_FULL_RESET = (64'd4 << FRAC_BITS) / 64'd800;
   localparam logic [12:0] WIDTH_RESET     = 13'd800;
   localparam logic [12:0] HEIGHT_RESET    = 13'd600;
   localparam logic [15:0] CAP_RESET       = 16'd256;

   logic [63:0] center_re_ff, center_re_in, center_im_ff, center_im_in;
   logic [62:0] pixel_step_ff, pixel_step_in;
   logic [12:0] frame_width_ff, frame_width_in, frame_height_ff, frame_height_in;
   logic [15:0] iteration_cap_ff, iteration_cap_in;

   logic               csr_write;
   logic [2:0]         csr_index;
   mep_pkg::cfg_type   cfg;
   logic               push_valid, push_ready, pop_valid, pop_ready;
   mep_pkg::coord_type push_data, pop_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[5:3];

   // Register writes on the access cycle of a write transaction.
   always_comb begin
      center_re_in     = center_re_ff;
      center_im_in     = center_im_ff;
      pixel_step_in    = pixel_step_ff;
      frame_width_in   = frame_width_ff;
      frame_height_in  = frame_height_ff;
      iteration_cap_in = iteration_cap_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CENTER_RE:     center_re_in     = csr_pwdata;
            REG_CENTER_IM:     center_im_in     = csr_pwdata;
            REG_PIXEL_STEP:    pixel_step_in    = csr_pwdata[62:0];
            REG_FRAME_WIDTH:   frame_width_in   = csr_pwdata[12:0];
            REG_FRAME_HEIGHT:  frame_height_in  = csr_pwdata[12:0];
            REG_ITERATION_CAP: iteration_cap_in = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         REG_CENTER_RE:     csr_prdata = center_re_ff;
         REG_CENTER_IM:     csr_prdata = center_im_ff;
         REG_PIXEL_STEP:    csr_prdata = {1'b0, pixel_step_ff};
         REG_FRAME_WIDTH:   csr_prdata = {51'd0, frame_width_ff};
         REG_FRAME_HEIGHT:  csr_prdata = {51'd0, frame_height_ff};
         REG_ITERATION_CAP: csr_prdata = {48'd0, iteration_cap_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_re_ff     <= CENTER_RE_RESET;
         center_im_ff     <= '0;
         pixel_step_ff    <= STEP_FULL_RESET[62:0];
         frame_width_ff   <= WIDTH_RESET;
         frame_height_ff  <= HEIGHT_RESET;
         iteration_cap_ff <= CAP_RESET;
      end else begin
         center_re_ff     <= center_re_in;
         center_im_ff     <= center_im_in;
         pixel_step_ff    <= pixel_step_in;
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         iteration_cap_ff <= iteration_cap_in;
      end
   end

   assign cfg.center_re     = center_re_ff;
   assign cfg.center_im     = center_im_ff;
   assign cfg.pixel_step    = pixel_step_ff;
   assign cfg.frame_width   = frame_width_ff;
   assign cfg.frame_height  = frame_height_ff;
   assign cfg.iteration_cap = iteration_cap_ff;

   // Coordinate mapping.
   mep_front #(
      .PIXEL_COORD_BITS(PIXEL_COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // Queue between mapping and iteration.
   mep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Iteration and coloring.
   mep_core #(
      .FRAC_BITS(FRAC_BITS)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .q_valid             (pop_valid),
      .q_ready             (pop_ready),
      .q_data              (pop_data),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_in_set          (rsp_in_set),
      .rsp_pixel_argb      (rsp_pixel_argb)
   );

`ifndef SYNTHESIS
   // A pixel inside the set is always black.
   a_in_set_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_set) |-> (rsp_pixel_argb == 32'hFF00_0000))
      else $error("in-set result is not black");

   // Alpha is always opaque.
   a_alpha_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_argb[31:24] == 8'hFF))
      else $error("result alpha is not opaque");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
